>>> hdl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants of the stereo feedforward echo core.
// ----------------------------------------------------------------------------
package sfe_pkg;

    // delay line length per channel
    localparam int DEPTH    = 65536;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DELAY_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int SMP_W    = 24;
    localparam int PROD_W   = GAIN_W + SMP_W;
    localparam int SUM_W    = SMP_W + 3;
    localparam int RND_SH   = 14;
    localparam int CMP_W    = (ADDR_W > DELAY_W) ? ADDR_W : DELAY_W;
    localparam int RAM_AW   = ADDR_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMP_W-1:0]  MAX_DELAY = CMP_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] LAST_POS  = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(DEPTH);

    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(8192);
    localparam logic signed [SUM_W-1:0]  SAT_HI   = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0]  SAT_LO   = -SUM_W'(8388608);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_DELAY  = 2'd0,
        REG_RIGHT_DELAY = 2'd1,
        REG_LEFT_GAIN   = 2'd2,
        REG_RIGHT_GAIN  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_in;
        logic                    is_right;
    } smp_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    out_is_right;
    } res_item_t;

    // memory request and lookup status from the address unit
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [RAM_AW-1:0] raddr;
        logic              hit;
        logic              bypass;
    } addr_req_t;

    // item metadata waiting for its memory read
    typedef struct packed {
        logic signed [SMP_W-1:0]  x;
        logic                     is_right;
        logic signed [GAIN_W-1:0] gain;
        logic                     hit;
        logic                     bypass;
    } s1_meta_t;

endpackage

>>> hdl/sfe_ram.sv
// ----------------------------------------------------------------------------
// sfe_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfe_ram #(
    parameter int AW = 17,
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW) - 1];

    // read-first on an address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/sfe_addr.sv
// ----------------------------------------------------------------------------
// sfe_addr
// Write pointers per channel, tap address generation and fill tracking.
// ----------------------------------------------------------------------------
module sfe_addr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          is_right,
    input  logic [sfe_pkg::DELAY_W-1:0]   left_delay,
    input  logic [sfe_pkg::DELAY_W-1:0]   right_delay,
    output sfe_pkg::addr_req_t            req
);
    import sfe_pkg::*;

    logic [ADDR_W-1:0] wp_reg [0:1];
    logic [ADDR_W-1:0] wp_next [0:1];
    logic [1:0]        wrapped_reg;
    logic [1:0]        wrapped_next;

    logic [CMP_W-1:0]  d_ext;
    logic [ADDR_W-1:0] d;
    logic [ADDR_W-1:0] w;
    logic [ADDR_W:0]   diff;
    logic [ADDR_W:0]   rd_full;
    logic              bypass;

    always_comb
    begin
        bypass = (left_delay == '0) && (right_delay == '0);
        d_ext  = is_right ? CMP_W'(right_delay) : CMP_W'(left_delay);
        if (d_ext > MAX_DELAY)
        begin
            d_ext = MAX_DELAY;
        end
        d       = d_ext[ADDR_W-1:0];
        w       = wp_reg[is_right];
        diff    = {1'b0, w} - {1'b0, d};
        rd_full = diff[ADDR_W] ? (diff + DEPTH_EXT) : diff;

        // before the first wrap only entries below the pointer hold samples
        req.hit    = wrapped_reg[is_right] || (!diff[ADDR_W] && (d != '0));
        req.raddr  = {is_right, rd_full[ADDR_W-1:0]};
        req.waddr  = {is_right, w};
        req.we     = accept && !bypass;
        req.bypass = bypass;
    end

    always_comb
    begin
        wp_next[0]   = wp_reg[0];
        wp_next[1]   = wp_reg[1];
        wrapped_next = wrapped_reg;
        if (req.we)
        begin
            if (w == LAST_POS)
            begin
                wp_next[is_right]      = '0;
                wrapped_next[is_right] = 1'b1;
            end
            else
            begin
                wp_next[is_right] = w + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg[0]   <= '0;
            wp_reg[1]   <= '0;
            wrapped_reg <= '0;
        end
        else
        begin
            wp_reg[0]   <= wp_next[0];
            wp_reg[1]   <= wp_next[1];
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

>>> hdl/sfe_mac.sv
// ----------------------------------------------------------------------------
// sfe_mac
// Gain multiply, rounding, mix with the dry sample and saturation.
// ----------------------------------------------------------------------------
module sfe_mac (
    input  logic                              clk,
    input  logic                              en2,
    input  logic                              en_o,
    input  sfe_pkg::s1_meta_t                 s1,
    input  logic [sfe_pkg::SMP_W-1:0]         rdata,
    output sfe_pkg::res_item_t                res
);
    import sfe_pkg::*;

    logic signed [SMP_W-1:0]  delayed;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SMP_W-1:0]  x_reg;
    logic                     right_reg;
    logic                     bypass_reg;

    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  sum;
    res_item_t                res_next;
    res_item_t                res_reg;

    // entries never written read as silence
    always_comb
    begin
        delayed   = s1.hit ? $signed(rdata) : '0;
        prod_next = PROD_W'(s1.gain) * PROD_W'(delayed);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod_reg   <= prod_next;
            x_reg      <= s1.x;
            right_reg  <= s1.is_right;
            bypass_reg <= s1.bypass;
        end
    end

    // round half up from Q3.37 to Q.23, then clamp
    always_comb
    begin
        rnd = (prod_reg + RND_BIAS) >>> RND_SH;
        sum = SUM_W'(x_reg) + SUM_W'(rnd);
        res_next.out_is_right = right_reg;
        if (bypass_reg)
        begin
            res_next.sample_out = x_reg;
        end
        else if (sum > SAT_HI)
        begin
            res_next.sample_out = SAT_HI[SMP_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            res_next.sample_out = SAT_LO[SMP_W-1:0];
        end
        else
        begin
            res_next.sample_out = sum[SMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> hdl/stereo_feedforward_echo_core.sv
// ----------------------------------------------------------------------------
// stereo_feedforward_echo_core
// Stereo feedforward comb echo with per-channel delay, gain and delay line.
// ----------------------------------------------------------------------------
// A sample transfer is taken every cycle unless held by res_stall; memory read,
// multiply, and mix and saturate are each one stage. The rate is set by the
// single delay line memory of 2*DEPTH words of 24 bits, which takes one read
// and one write per cycle; each stage holds its item on its own, so bubbles
// fill while a result waits on res_stall. No clearing pass follows reset: per
// channel fill tracking makes entries never written read as zero. Delays of
// zero on both channels pass samples through with no change to the delay lines.
// Configuration writes must come while the core is idle, which is not enforced.
// ----------------------------------------------------------------------------
module stereo_feedforward_echo_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             smp_valid,
    output logic                             smp_stall,
    input  sfe_pkg::smp_item_t               smp_data,
    output logic                             res_valid,
    input  logic                             res_stall,
    output sfe_pkg::res_item_t               res_data,
    input  logic                             cfg_we,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfe_pkg::DELAY_W-1:0]      cfg_data
);
    import sfe_pkg::*;

    logic [DELAY_W-1:0]       left_delay_reg;
    logic [DELAY_W-1:0]       right_delay_reg;
    logic signed [GAIN_W-1:0] left_gain_reg;
    logic signed [GAIN_W-1:0] right_gain_reg;

    logic      en1;
    logic      en2;
    logic      en_o;
    logic      smp_accept;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    addr_req_t          req;
    s1_meta_t           s1_reg;
    s1_meta_t           s1_next;
    logic [SMP_W-1:0]   rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_delay_reg  <= '0;
            right_delay_reg <= '0;
            left_gain_reg   <= '0;
            right_gain_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT_DELAY:  left_delay_reg  <= cfg_data;
                REG_RIGHT_DELAY: right_delay_reg <= cfg_data;
                REG_LEFT_GAIN:   left_gain_reg   <= $signed(cfg_data);
                REG_RIGHT_GAIN:  right_gain_reg  <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // each stage moves when the one after it is empty or moving
    always_comb
    begin
        en_o           = !out_valid_reg || !res_stall;
        en2            = !s2_valid_reg || en_o;
        en1            = !s1_valid_reg || en2;
        smp_stall      = !en1;
        smp_accept     = smp_valid && en1;
        s1_valid_next  = en1  ? smp_accept   : s1_valid_reg;
        s2_valid_next  = en2  ? s1_valid_reg : s2_valid_reg;
        out_valid_next = en_o ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    sfe_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (smp_accept),
        .is_right    (smp_data.is_right),
        .left_delay  (left_delay_reg),
        .right_delay (right_delay_reg),
        .req         (req)
    );

    // the sample is written on transfer; read-first covers a zero delay
    sfe_ram #(
        .AW (RAM_AW),
        .DW (SMP_W)
    ) u_ram (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (smp_data.sample_in),
        .re    (en1),
        .raddr (req.raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_next.x        = smp_data.sample_in;
        s1_next.is_right = smp_data.is_right;
        s1_next.gain     = smp_data.is_right ? right_gain_reg : left_gain_reg;
        s1_next.hit      = req.hit;
        s1_next.bypass   = req.bypass;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
    end

    sfe_mac u_mac (
        .clk   (clk),
        .en2   (en2),
        .en_o  (en_o),
        .s1    (s1_reg),
        .rdata (rdata),
        .res   (res_data)
    );

    assign res_valid = out_valid_reg;

    a_write_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> smp_accept)
        else $error("delay line written without a sample transfer");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        smp_accept |=> s1_valid_reg)
        else $error("transferred sample did not enter the read stage");

    // read data of a never written entry is unused, so only a hit must hold
    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en2) |=>
            (s1_valid_reg && $stable(s1_reg) && (!s1_reg.hit || $stable(rdata))))
        else $error("read stage lost its item while blocked");

endmodule

>>> verif/tb_stereo_feedforward_echo_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_feedforward_echo_core
// Self-checking bench for the stereo feedforward echo core.
// ----------------------------------------------------------------------------
// Sample transfers are driven in random bursts while the result side stalls on
// its own pattern. A scoreboard keeps its own copy of both delay lines, write
// positions and settings, and compares every result with the predicted echo.
// A directed part covers bypass, saturation and the zero-delay read; random
// phases with new settings follow, each one drained before the next settings
// are written.
// ----------------------------------------------------------------------------
module tb_stereo_feedforward_echo_core;

    import sfe_pkg::*;

    localparam int CLK_HALF    = 4;
    // about 860 transfers with their random gaps stay well under this limit
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 70;

    class echo_scoreboard;
        bit [SMP_W-1:0]          line_mem [2][DEPTH];
        int unsigned             wr_pos [2];
        logic [DELAY_W-1:0]      delay [2];
        logic signed [GAIN_W-1:0] gain [2];
        res_item_t               expected_echoes [$];
        int                      errors;
        int                      checked;
        int                      noted;

        function void set_reg(cfg_reg_t idx, logic [DELAY_W-1:0] val);
            case (idx)
                REG_LEFT_DELAY:  delay[0] = val;
                REG_RIGHT_DELAY: delay[1] = val;
                REG_LEFT_GAIN:   gain[0] = val;
                REG_RIGHT_GAIN:  gain[1] = val;
                default: ;
            endcase
        endfunction

        function void note_sample(smp_item_t s);
            res_item_t   r;
            int          ch;
            int unsigned d;
            int unsigned rd;
            longint      x;
            longint      dl;
            longint      acc;
            ch = int'(s.is_right);
            x = longint'($signed(s.sample_in));
            r.out_is_right = s.is_right;
            r.sample_out = s.sample_in;
            // both delays zero means bypass with no state change
            if (delay[0] != 0 || delay[1] != 0)
            begin
                d = delay[ch];
                if (d > DEPTH - 1)
                    d = DEPTH - 1;
                rd = (wr_pos[ch] + DEPTH - d) % DEPTH;
                dl = longint'($signed(line_mem[ch][rd]));
                // round half up: add half an lsb, then floor shift
                acc = x + ((longint'(gain[ch]) * dl + 8192) >>> 14);
                if (acc > 8388607)
                    acc = 8388607;
                if (acc < -8388608)
                    acc = -8388608;
                r.sample_out = acc[SMP_W-1:0];
                line_mem[ch][wr_pos[ch]] = s.sample_in;
                wr_pos[ch] = (wr_pos[ch] + 1) % DEPTH;
            end
            expected_echoes.push_back(r);
            noted++;
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            if (expected_echoes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: sample %0d right %b",
                             $signed(got.sample_out), got.out_is_right);
                return;
            end
            want = expected_echoes.pop_front();
            checked++;
            if (got.sample_out !== want.sample_out || got.out_is_right !== want.out_is_right)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch on result %0d: expected sample %0d right %b, ",
                              "got sample %0d right %b"},
                             checked, $signed(want.sample_out), want.out_is_right,
                             $signed(got.sample_out), got.out_is_right);
            end
        endfunction

        function int pending();
            return expected_echoes.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               smp_valid;
    logic               smp_stall;
    smp_item_t          smp_data;
    logic               res_valid;
    logic               res_stall;
    res_item_t          res_data;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DELAY_W-1:0] cfg_data;

    echo_scoreboard sb = new();
    int             burst_left = 1;
    int             settings_used = 0;
    longint         cycles = 0;

    stereo_feedforward_echo_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, sb.pending());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: stall pattern changes mode after a random span
    initial
    begin
        int mode;
        int span;
        res_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 3) == 0);
                    2: res_stall <= 1'($urandom_range(0, 1));
                    default: res_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_data);
    end

    function automatic smp_item_t sample_of(int v, bit right);
        smp_item_t s;
        s.sample_in = v[SMP_W-1:0];
        s.is_right = right;
        return s;
    endfunction

    function automatic smp_item_t rand_sample();
        smp_item_t s;
        int        pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: s.sample_in = 24'sd8388607;
            1: s.sample_in = -24'sd8388608;
            2: s.sample_in = SMP_W'($urandom_range(0, 200) - 100);
            3: s.sample_in = {SMP_W{$urandom_range(0, 1) == 1}};
            default: s.sample_in = SMP_W'($urandom());
        endcase
        s.is_right = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic logic [DELAY_W-1:0] rand_delay();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return '0;
        else if (pick < 65)
            return DELAY_W'($urandom_range(1, 16));
        else if (pick < 85)
            return DELAY_W'($urandom_range(17, 2000));
        else if (pick < 95)
            return '1;
        return DELAY_W'($urandom_range(60000, 65534));
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'h7fff;
        else if (pick < 20)
            return 16'h8000;
        else if (pick < 28)
            return 16'h4000;
        else if (pick < 35)
            return 16'hc000;
        else if (pick < 45)
            return '0;
        return GAIN_W'($urandom());
    endfunction

    task automatic drive_sample(input smp_item_t s);
        @(negedge clk);
        smp_valid <= 1'b1;
        smp_data  <= s;
        do
            @(posedge clk);
        while (smp_stall);
        sb.note_sample(s);
    endtask

    // bursts of random length with random gaps, sometimes none
    task automatic sender_pace();
        int gap;
        int pick;
        burst_left--;
        if (burst_left <= 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(8, 40);
            repeat (gap)
            begin
                @(negedge clk);
                smp_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 32);
        end
    endtask

    task automatic play_list(input smp_item_t q[$]);
        foreach (q[k])
        begin
            drive_sample(q[k]);
            sender_pace();
        end
    endtask

    task automatic play_random(input int count);
        repeat (count)
        begin
            drive_sample(rand_sample());
            sender_pace();
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        smp_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // pipeline is three stages deep
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DELAY_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(input logic [DELAY_W-1:0] ldly, input logic [DELAY_W-1:0] rdly,
                                input logic [GAIN_W-1:0] lgain, input logic [GAIN_W-1:0] rgain);
        write_reg(REG_LEFT_DELAY, ldly);
        write_reg(REG_RIGHT_DELAY, rdly);
        write_reg(REG_LEFT_GAIN, lgain);
        write_reg(REG_RIGHT_GAIN, rgain);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        smp_item_t q [$];
        smp_valid <= 1'b0;
        smp_data  <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_LEFT_DELAY;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bypass: both delays zero
        apply_config('0, '0, 16'h7fff, 16'h8000);
        q = {sample_of(8388607, 0), sample_of(-8388608, 1),
             sample_of(0, 0), sample_of(-1, 1)};
        play_list(q);
        wait_drained();

        // saturation both ways on left, right delay zero reads the oldest entry
        apply_config(16'd1, '0, 16'h7fff, 16'h8000);
        q = {sample_of(8388607, 0), sample_of(8388607, 0), sample_of(-8388608, 0),
             sample_of(-8388608, 0), sample_of(0, 0), sample_of(8388607, 1),
             sample_of(-8388608, 1)};
        play_list(q);
        wait_drained();

        // left delay zero, right delay two with unity gain
        apply_config('0, 16'd2, 16'h8000, 16'h4000);
        q = {sample_of(1000, 1), sample_of(-3, 1), sample_of(5, 1),
             sample_of(8388607, 1), sample_of(8388607, 1), sample_of(12345, 0),
             sample_of(-12345, 0)};
        play_list(q);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                2: apply_config('0, '0, rand_gain(), rand_gain());
                5: apply_config('1, '1, 16'h8000, 16'h7fff);
                8: apply_config('0, '1, rand_gain(), rand_gain());
                default: apply_config(rand_delay(), rand_delay(), rand_gain(), rand_gain());
            endcase
            play_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("run covered %0d sample transfers over %0d register settings",
                 sb.noted, settings_used);
        $display("%0d results compared, %0d errors, %0d cycles", sb.checked, sb.errors, cycles);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> stereo_feedforward_echo_core.f
hdl/sfe_pkg.sv
hdl/sfe_ram.sv
hdl/sfe_addr.sv
hdl/sfe_mac.sv
hdl/stereo_feedforward_echo_core.sv
verif/tb_stereo_feedforward_echo_core.sv
